// File: hdl/psm_pkg.sv
`timescale 1ns / 1ps

package psm_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int PREFIX_MAX_DEF = 8;
    localparam int SUFFIX_MAX_DEF = 8;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths
    localparam int FIELD_W    = 16;   // run_start / run_length
    localparam int LEN_W      = 4;    // length fields in layout
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LAYOUT_W   = 10;
    localparam int CLASS_W    = 256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_3 = 3'd6;

    // Layout bit positions
    localparam int LAY_PLEN_LO  = 0;
    localparam int LAY_SLEN_LO  = 4;
    localparam int LAY_PRESENT  = 8;
    localparam int LAY_ANCHORED = 9;

    // Per-string scan phase
    typedef enum logic [4:0] {
        PH_PREFIX = 5'b00001,
        PH_RUN    = 5'b00010,
        PH_SUFFIX = 5'b00100,
        PH_OK     = 5'b01000,
        PH_FAIL   = 5'b10000
    } t_phase;

    // Live configuration seen by the scanner
    typedef struct packed {
        logic [CFG_DATA_W-1:0] prefix;
        logic [CFG_DATA_W-1:0] suffix;
        logic [LAYOUT_W-1:0]   layout;
        logic [CLASS_W-1:0]    class_set;
    } t_cfg;

    // One result
    typedef struct packed {
        logic               matched;
        logic [FIELD_W-1:0] run_start;
        logic [FIELD_W-1:0] run_length;
        logic               overflow;
    } t_result;

endpackage

// File: hdl/prefix_span_suffix_matcher_top.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                 | Fields
// ---------+-----+---------------------------+-----------------------------------------------
// input    | in  | i_in_valid / o_in_stall   | i_text_byte, i_end_of_text
// output   | out | o_out_valid / i_out_stall | o_matched, o_run_start, o_run_length, o_overflow
// config   | in  | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One byte per cycle. A byte lands in the input register, and the scan logic then updates the
// string state from it; a final byte also loads the result register, which presents its result.
// Only a final byte waits, and only while the result register is full and stalled.
// Synchronous active-low reset clears the configuration and the string state.

module prefix_span_suffix_matcher_top #(
    parameter int PREFIX_MAX = psm_pkg::PREFIX_MAX_DEF,
    parameter int SUFFIX_MAX = psm_pkg::SUFFIX_MAX_DEF,
    parameter int COUNT_BITS = psm_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_text_byte,
    input  logic                            i_end_of_text,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_matched,
    output logic [psm_pkg::FIELD_W-1:0]     o_run_start,
    output logic [psm_pkg::FIELD_W-1:0]     o_run_length,
    output logic                            o_overflow,
    input  logic                            i_cfg_we,
    input  logic [psm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [psm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    psm_pkg::t_cfg    cfg;
    psm_pkg::t_result scan_res;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_eot;
    logic       r_out_valid;
    psm_pkg::t_result r_res;

    logic out_free, step, in_take, out_take;

    assign out_take = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign step     = r_in_valid && (!r_eot || out_free);
    assign o_in_stall = r_in_valid && !step;
    assign in_take  = i_in_valid && !o_in_stall;

    psm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    psm_scan #(
        .PREFIX_MAX (PREFIX_MAX),
        .SUFFIX_MAX (SUFFIX_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_byte),
        .i_eot    (r_eot),
        .i_cfg    (cfg),
        .o_result (scan_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= i_text_byte;
            r_eot  <= i_end_of_text;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_eot) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_eot) begin
            r_res <= scan_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_matched    = r_res.matched;
    assign o_run_start  = r_res.run_start;
    assign o_run_length = r_res.run_length;
    assign o_overflow   = r_res.overflow;

endmodule

// File: hdl/psm_cfg.sv
`timescale 1ns / 1ps

module psm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [psm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [psm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output psm_pkg::t_cfg                    o_cfg
);

    logic [psm_pkg::CFG_DATA_W-1:0] r_prefix;
    logic [psm_pkg::CFG_DATA_W-1:0] r_suffix;
    logic [psm_pkg::LAYOUT_W-1:0]   r_layout;
    logic [psm_pkg::CFG_DATA_W-1:0] r_class0;
    logic [psm_pkg::CFG_DATA_W-1:0] r_class1;
    logic [psm_pkg::CFG_DATA_W-1:0] r_class2;
    logic [psm_pkg::CFG_DATA_W-1:0] r_class3;

    // Register writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
            r_suffix <= '0;
            r_layout <= '0;
            r_class0 <= '0;
            r_class1 <= '0;
            r_class2 <= '0;
            r_class3 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psm_pkg::CFG_PREFIX:  r_prefix <= i_cfg_data;
                psm_pkg::CFG_SUFFIX:  r_suffix <= i_cfg_data;
                psm_pkg::CFG_LAYOUT:  r_layout <= i_cfg_data[psm_pkg::LAYOUT_W-1:0];
                psm_pkg::CFG_CLASS_0: r_class0 <= i_cfg_data;
                psm_pkg::CFG_CLASS_1: r_class1 <= i_cfg_data;
                psm_pkg::CFG_CLASS_2: r_class2 <= i_cfg_data;
                psm_pkg::CFG_CLASS_3: r_class3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.prefix    = r_prefix;
    assign o_cfg.suffix    = r_suffix;
    assign o_cfg.layout    = r_layout;
    assign o_cfg.class_set = {r_class3, r_class2, r_class1, r_class0};

endmodule

// File: hdl/psm_scan.sv
`timescale 1ns / 1ps

module psm_scan #(
    parameter int PREFIX_MAX = psm_pkg::PREFIX_MAX_DEF,
    parameter int SUFFIX_MAX = psm_pkg::SUFFIX_MAX_DEF,
    parameter int COUNT_BITS = psm_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_eot,
    input  psm_pkg::t_cfg     i_cfg,
    output psm_pkg::t_result  o_result
);

    localparam int LW     = psm_pkg::LEN_W;
    localparam int FW     = psm_pkg::FIELD_W;
    localparam int SIDX_W = $clog2(SUFFIX_MAX + 1);
    localparam int PW     = COUNT_BITS + 1;

    // Per-string state
    psm_pkg::t_phase                  r_phase, n_phase;
    logic [PREFIX_MAX-1:0][7:0]       r_recent;
    logic [PREFIX_MAX-1:0][7:0]       n_recent;
    logic [COUNT_BITS-1:0]            r_pos, n_pos;
    logic [COUNT_BITS-1:0]            r_start, n_start;
    logic [COUNT_BITS-1:0]            r_run, n_run;
    logic [SIDX_W-1:0]                r_sidx, n_sidx;
    logic                             r_ovf, n_ovf;

    // Decoded layout
    logic [LW-1:0] plen_raw, slen_raw, plen_c, slen_c;
    logic          present, anchored;

    assign plen_raw = i_cfg.layout[psm_pkg::LAY_PLEN_LO +: LW];
    assign slen_raw = i_cfg.layout[psm_pkg::LAY_SLEN_LO +: LW];
    assign present  = i_cfg.layout[psm_pkg::LAY_PRESENT];
    assign anchored = i_cfg.layout[psm_pkg::LAY_ANCHORED];
    assign plen_c   = (plen_raw > LW'(PREFIX_MAX)) ? LW'(PREFIX_MAX) : plen_raw;
    assign slen_c   = (slen_raw > LW'(SUFFIX_MAX)) ? LW'(SUFFIX_MAX) : slen_raw;

    // Window of the newest bytes, newest in the top lane
    always_comb begin
        for (int k = 0; k < PREFIX_MAX - 1; k++) begin
            n_recent[k] = r_recent[k+1];
        end
        n_recent[PREFIX_MAX-1] = i_byte;
    end

    // Prefix compare: one candidate per length, picked by the live length
    logic pre_hit;
    always_comb begin
        logic h;
        pre_hit = 1'b0;
        for (int p = 1; p <= PREFIX_MAX; p++) begin
            h = 1'b1;
            for (int j = 0; j < p; j++) begin
                if (n_recent[PREFIX_MAX-p+j] != i_cfg.prefix[8*j +: 8]) h = 1'b0;
            end
            if (plen_c == LW'(p)) pre_hit = h;
        end
    end

    // Class membership of the current byte
    logic is_member;
    assign is_member = i_cfg.class_set[i_byte];

    logic pos_full, pos_reach;
    assign pos_full  = &r_pos;
    assign pos_reach = (PW'(r_pos) + PW'(1)) >= PW'(plen_c);

    // Next-state logic: prefix, then run, then suffix, all on this byte
    logic       consumed;
    logic [7:0] s_byte;
    logic       matched;
    always_comb begin
        n_phase  = r_phase;
        n_start  = r_start;
        n_run    = r_run;
        n_sidx   = r_sidx;
        n_ovf    = r_ovf;
        consumed = 1'b0;
        s_byte   = '0;

        // prefix search
        if (r_phase == psm_pkg::PH_PREFIX) begin
            if (!present) begin
                n_phase = psm_pkg::PH_RUN;
                n_start = r_pos;
            end else if (plen_c == '0) begin
                n_phase = psm_pkg::PH_FAIL;
            end else if (pos_reach) begin
                consumed = 1'b1;
                if (pre_hit) begin
                    n_phase = psm_pkg::PH_RUN;
                    if (pos_full) begin
                        n_start = r_pos;
                        n_ovf   = 1'b1;
                    end else begin
                        n_start = r_pos + COUNT_BITS'(1);
                    end
                end else if (anchored) begin
                    n_phase = psm_pkg::PH_FAIL;
                end
            end else begin
                consumed = 1'b1;
            end
        end

        // class run
        if (!consumed && n_phase == psm_pkg::PH_RUN) begin
            if (is_member) begin
                consumed = 1'b1;
                if (&r_run) begin
                    n_ovf = 1'b1;
                end else begin
                    n_run = r_run + COUNT_BITS'(1);
                end
            end else if (r_run == '0) begin
                consumed = 1'b1;
                n_phase  = psm_pkg::PH_FAIL;
            end else begin
                n_phase = psm_pkg::PH_SUFFIX;
                n_sidx  = '0;
            end
        end

        // suffix check
        for (int j = 0; j < SUFFIX_MAX; j++) begin
            if (n_sidx == SIDX_W'(j)) s_byte = i_cfg.suffix[8*j +: 8];
        end
        if (!consumed && n_phase == psm_pkg::PH_SUFFIX) begin
            if ((LW+1)'(n_sidx) >= (LW+1)'(slen_c)) begin
                n_phase = psm_pkg::PH_OK;
            end else if (s_byte == i_byte) begin
                n_sidx = n_sidx + SIDX_W'(1);
                if ((LW+1)'(n_sidx) >= (LW+1)'(slen_c)) n_phase = psm_pkg::PH_OK;
            end else begin
                n_phase = psm_pkg::PH_FAIL;
            end
        end

        // position
        if (pos_full) begin
            n_pos = r_pos;
            n_ovf = 1'b1;
        end else begin
            n_pos = r_pos + COUNT_BITS'(1);
        end

        // verdict for a final byte
        matched = (n_phase == psm_pkg::PH_OK)
               || (n_phase == psm_pkg::PH_RUN && n_run != '0 && slen_c == '0)
               || (n_phase == psm_pkg::PH_SUFFIX
                   && (LW+1)'(n_sidx) >= (LW+1)'(slen_c));
    end

    assign o_result.matched    = matched;
    assign o_result.run_start  = matched ? FW'(n_start) : '0;
    assign o_result.run_length = matched ? FW'(n_run) : '0;
    assign o_result.overflow   = n_ovf;

    // State update; the final byte returns the string state to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= psm_pkg::PH_PREFIX;
            r_pos   <= '0;
            r_start <= '0;
            r_run   <= '0;
            r_sidx  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_step) begin
            if (i_eot) begin
                r_phase <= psm_pkg::PH_PREFIX;
                r_pos   <= '0;
                r_start <= '0;
                r_run   <= '0;
                r_sidx  <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_start <= n_start;
                r_run   <= n_run;
                r_sidx  <= n_sidx;
                r_ovf   <= n_ovf;
            end
        end
    end

    // Byte window only feeds compares once it holds this string's bytes
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_recent <= n_recent;
        end
    end

endmodule
